[hw/rtl/lcdw_pkg.sv]
package lcdw_pkg;

  // Line image bit positions
  localparam int unsigned LN_RS  = 0;
  localparam int unsigned LN_RW  = 1;
  localparam int unsigned LN_E   = 2;
  localparam int unsigned LN_DB7 = 3;
  localparam int unsigned LN_DB6 = 4;
  localparam int unsigned LN_DB5 = 5;
  localparam int unsigned LN_DB4 = 6;
  localparam int unsigned LN_BL  = 7;

  localparam logic [7:0] IMAGE_RESET = 8'h80;

  // Last step index of each command's frame run
  localparam logic [3:0] LAST_BYTE      = 4'd12;
  localparam logic [3:0] LAST_NIBBLE    = 4'd5;
  localparam logic [3:0] LAST_BACKLIGHT = 4'd0;
  localparam logic [3:0] LAST_PARK      = 4'd6;

  // Nibble phases
  localparam logic [2:0] PH_DB7 = 3'd0;
  localparam logic [2:0] PH_DB6 = 3'd1;
  localparam logic [2:0] PH_DB5 = 3'd2;
  localparam logic [2:0] PH_DB4 = 3'd3;
  localparam logic [2:0] PH_EHI = 3'd4;
  localparam logic [2:0] PH_ELO = 3'd5;

  // Park steps
  localparam logic [3:0] PK_RS  = 4'd0;
  localparam logic [3:0] PK_RW  = 4'd1;
  localparam logic [3:0] PK_E   = 4'd2;
  localparam logic [3:0] PK_DB7 = 4'd3;
  localparam logic [3:0] PK_DB6 = 4'd4;
  localparam logic [3:0] PK_DB5 = 4'd5;
  localparam logic [3:0] PK_DB4 = 4'd6;

  localparam logic [3:0] BYTE_HI_END = 4'd6;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_NIBBLE    = 2'd1,
    OP_BACKLIGHT = 2'd2,
    OP_PARK      = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] nib_hi;
    logic [3:0] nib_lo;
    logic       rs;
    logic       bl;
    logic [3:0] last_step;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  function automatic logic [7:0] put_nib(logic [7:0] img, logic [2:0] ph, logic [3:0] nib);
    logic [7:0] r;
    r = img;
    case (ph)
      PH_DB7:  r[LN_DB7] = nib[3];
      PH_DB6:  r[LN_DB6] = nib[2];
      PH_DB5:  r[LN_DB5] = nib[1];
      PH_DB4:  r[LN_DB4] = nib[0];
      PH_EHI:  r[LN_E]   = 1'b1;
      PH_ELO:  r[LN_E]   = 1'b0;
      default: r = img;
    endcase
    return r;
  endfunction

  // One line change per frame, except that step 0 of a byte write sets both RW and RS
  function automatic logic [7:0] frame_step(logic [7:0] img, cmd_t c, logic [3:0] step);
    logic [7:0] r;
    r = img;
    case (c.op)
      OP_BYTE: begin
        if (step == 4'd0) begin
          r[LN_RW] = 1'b0;
          r[LN_RS] = c.rs;
        end else if (step <= BYTE_HI_END) begin
          r = put_nib(img, 3'(step - 4'd1), c.nib_hi);
        end else begin
          r = put_nib(img, 3'(step - 4'd7), c.nib_lo);
        end
      end
      OP_NIBBLE:    r = put_nib(img, step[2:0], c.nib_hi);
      OP_BACKLIGHT: r[LN_BL] = c.bl;
      OP_PARK: begin
        case (step)
          PK_RS:   r[LN_RS]  = 1'b1;
          PK_RW:   r[LN_RW]  = 1'b1;
          PK_E:    r[LN_E]   = 1'b0;
          PK_DB7:  r[LN_DB7] = 1'b1;
          PK_DB6:  r[LN_DB6] = 1'b1;
          PK_DB5:  r[LN_DB5] = 1'b1;
          PK_DB4:  r[LN_DB4] = 1'b1;
          default: r = img;
        endcase
      end
      default: r = img;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/lcdw_front.sv]
module lcdw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_register_select,
  input  logic                 in_backlight_on,
  input  lcdw_pkg::q_stat_t    q_stat,
  output logic                 q_push,
  output lcdw_pkg::cmd_t       q_wdata
);

  logic           fe_valid_r, fe_valid_nxt;
  lcdw_pkg::cmd_t fe_cmd_r, fe_cmd_nxt;
  lcdw_pkg::cmd_t cls;
  logic           take;

  // classify: opcode decode, nibble split, run length
  always_comb begin
    cls.op     = lcdw_pkg::op_t'(in_opcode);
    cls.nib_hi = in_data_byte[7:4];
    cls.nib_lo = in_data_byte[3:0];
    cls.rs     = in_register_select;
    cls.bl     = in_backlight_on;
    case (lcdw_pkg::op_t'(in_opcode))
      lcdw_pkg::OP_BYTE:      cls.last_step = lcdw_pkg::LAST_BYTE;
      lcdw_pkg::OP_NIBBLE:    cls.last_step = lcdw_pkg::LAST_NIBBLE;
      lcdw_pkg::OP_BACKLIGHT: cls.last_step = lcdw_pkg::LAST_BACKLIGHT;
      lcdw_pkg::OP_PARK:      cls.last_step = lcdw_pkg::LAST_PARK;
      default:                cls.last_step = lcdw_pkg::LAST_BACKLIGHT;
    endcase
  end

  assign q_push   = fe_valid_r && !q_stat.full;
  assign q_wdata  = fe_cmd_r;
  assign in_stall = fe_valid_r && q_stat.full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    fe_valid_nxt = fe_valid_r;
    fe_cmd_nxt   = fe_cmd_r;
    if (q_push) fe_valid_nxt = 1'b0;
    if (take) begin
      fe_valid_nxt = 1'b1;
      fe_cmd_nxt   = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
    fe_cmd_r <= fe_cmd_nxt;
  end

endmodule

[hw/rtl/lcdw_queue.sv]
module lcdw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcdw_pkg::cmd_t    wdata,
  input  logic              pop,
  output lcdw_pkg::cmd_t    head,
  output lcdw_pkg::q_stat_t stat
);

  lcdw_pkg::cmd_t ent_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign stat.full      = (cnt_r == 2'd2);
  assign stat.not_empty = (cnt_r != 2'd0);
  assign head           = ent_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && stat.not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) ent_r[wr_ptr_r] <= wdata;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count missed a push");

endmodule

[hw/rtl/lcdw_back.sv]
module lcdw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lcdw_pkg::q_stat_t q_stat,
  input  lcdw_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_latched_frame,
  output logic              out_last_frame
);

  logic           busy_r, busy_nxt;
  logic [3:0]     step_r, step_nxt;
  lcdw_pkg::cmd_t cmd_r, cmd_nxt;
  logic [7:0]     image_r, image_nxt;
  logic           ov_r, ov_nxt;
  logic [7:0]     of_r, of_nxt;
  logic           ol_r, ol_nxt;

  lcdw_pkg::cmd_t cur;
  logic [3:0]     cur_step;
  logic           out_free, gen, is_last;
  logic [7:0]     img_new;

  // first frame of a command comes straight off the queue head
  assign cur      = busy_r ? cmd_r : q_head;
  assign cur_step = busy_r ? step_r : 4'd0;
  assign out_free = !ov_r || !out_stall;
  assign gen      = out_free && (busy_r || q_stat.not_empty);
  assign q_pop    = out_free && !busy_r && q_stat.not_empty;
  assign is_last  = (cur_step == cur.last_step);
  assign img_new  = lcdw_pkg::frame_step(image_r, cur, cur_step);

  always_comb begin
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    cmd_nxt   = cmd_r;
    image_nxt = image_r;
    ov_nxt    = ov_r && out_stall;
    of_nxt    = of_r;
    ol_nxt    = ol_r;
    if (gen) begin
      image_nxt = img_new;
      ov_nxt    = 1'b1;
      of_nxt    = img_new;
      ol_nxt    = is_last;
      cmd_nxt   = cur;
      busy_nxt  = !is_last;
      step_nxt  = cur_step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= 4'd0;
      image_r <= lcdw_pkg::IMAGE_RESET;
      ov_r    <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      step_r  <= step_nxt;
      image_r <= image_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r <= cmd_nxt;
    of_r  <= of_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid         = ov_r;
  assign out_latched_frame = of_r;
  assign out_last_frame    = ol_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r != 4'd0 && step_r <= cmd_r.last_step))
    else $error("step beyond command run");
  a_image_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    gen |=> (out_latched_frame == image_r))
    else $error("frame and line image diverged");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_pop)
    else $error("queue popped mid-run");
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (gen && is_last) |=> (!busy_r && out_last_frame))
    else $error("run did not close on its last frame");

endmodule

[hw/rtl/char_lcd_nibble_writer_via_shift_reg_unit.sv]
// HD44780 4-bit line sequencer for a display behind an 8-bit shift-register
// expander. Each accepted command beat yields a run of 8-bit line images, one
// LCD line changed per frame, except that the first frame of a byte write sets
// both RS and RW (bit0 RS, bit1 RW, bit2 E, bits3-6 DB7..DB4, bit7 backlight);
// out_last_frame marks the final frame of a run. Run lengths: byte write 13
// frames, nibble write 6, set backlight 1, park 7. The output register
// produces one frame per cycle while out_stall stays low and commands wait,
// with no gap between runs. The line image resets to 0x80 (backlight on, all
// other lines low). Commands are registered and decoded in the front end, pass
// through a two-entry queue, and the back-end sequencer walks their frames, so
// input beats keep flowing while results wait, until front end and queue fill.
module char_lcd_nibble_writer_via_shift_reg_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic       in_register_select,
  input  logic       in_backlight_on,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_latched_frame,
  output logic       out_last_frame
);

  lcdw_pkg::q_stat_t q_stat;
  lcdw_pkg::cmd_t    q_wdata;
  lcdw_pkg::cmd_t    q_head;
  logic              q_push;
  logic              q_pop;

  // front end: command register and decode
  lcdw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .in_register_select (in_register_select),
    .in_backlight_on    (in_backlight_on),
    .q_stat             (q_stat),
    .q_push             (q_push),
    .q_wdata            (q_wdata)
  );

  // decoupling queue
  lcdw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  // back end: frame sequencer, line image and output register
  lcdw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_latched_frame (out_latched_frame),
    .out_last_frame    (out_last_frame)
  );

endmodule
